@@ sv/multi_mode_byte_cipher_assert.svh @@
// ----------------------------------------------------------------------------
// Multi-mode byte cipher assertion macros
// Shared property templates, clocked on clk and disabled in rst.
// ----------------------------------------------------------------------------
`ifndef MULTI_MODE_BYTE_CIPHER_ASSERT_SVH
`define MULTI_MODE_BYTE_CIPHER_ASSERT_SVH

// same-cycle implication
`define MMBC_ASSERT_NOW(label, cond, expr, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (expr)) \
    else $error(msg);

// next-cycle implication
`define MMBC_ASSERT_NEXT(label, cond, expr, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (expr)) \
    else $error(msg);

`endif

@@ sv/mmbc_pkg.sv @@
// ----------------------------------------------------------------------------
// mmbc_pkg
// Types and constants shared by the multi-mode byte cipher modules.
// ----------------------------------------------------------------------------
`default_nettype none

package mmbc_pkg;

  localparam int PERM_DEPTH = 256;
  localparam int PERM_AW    = 8;

  // register indexes
  localparam logic [2:0] REG_MODE     = 3'd0;
  localparam logic [2:0] REG_XOR_KEY  = 3'd1;
  localparam logic [2:0] REG_VIG_KEY  = 3'd2;
  localparam logic [2:0] REG_RC4_LOW  = 3'd3;
  localparam logic [2:0] REG_RC4_HIGH = 3'd4;

  // mode codes
  localparam logic [2:0] MODE_PASS   = 3'd0;
  localparam logic [2:0] MODE_CAESAR = 3'd1;
  localparam logic [2:0] MODE_XOR    = 3'd2;
  localparam logic [2:0] MODE_VIG    = 3'd3;
  localparam logic [2:0] MODE_RC4    = 3'd4;

  // reset keys: "1234", "TAJNE", "1234567890123456"
  localparam logic [31:0] XOR_KEY_RST  = 32'h3433_3231;
  localparam logic [39:0] VIG_KEY_RST  = 40'h45_4E4A_4154;
  localparam logic [63:0] RC4_LOW_RST  = 64'h3837_3635_3433_3231;
  localparam logic [63:0] RC4_HIGH_RST = 64'h3635_3433_3231_3039;

  localparam logic [7:0] PRINT_LO     = 8'd32;
  localparam logic [7:0] PRINT_HI     = 8'd126;
  localparam logic [8:0] PRINT_SPAN   = 9'd95;
  localparam logic [6:0] CAESAR_SHIFT = 7'd3;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_FILL,
    ST_KS_RD_N,
    ST_KS_RD_J,
    ST_KS_WR_N,
    ST_KS_WR_J,
    ST_PR_RD_I,
    ST_PR_RD_J,
    ST_PR_WR_I,
    ST_PR_WR_J,
    ST_PR_KS,
    ST_DONE
  } ctrl_state_t;

  typedef enum logic [3:0] {
    OP_NONE,
    OP_LOAD,
    OP_FILL,
    OP_KS_RD_N,
    OP_KS_RD_J,
    OP_KS_WR_N,
    OP_KS_WR_J,
    OP_PR_RD_I,
    OP_PR_RD_J,
    OP_PR_WR_I,
    OP_PR_WR_J,
    OP_PR_KS,
    OP_FINISH
  } dp_op_t;

  typedef struct packed {
    dp_op_t op;
  } dp_cmd_t;

  typedef struct packed {
    logic sched_pending;
    logic rc4_mode;
    logic cnt_max;
    logic out_free;
  } dp_status_t;

endpackage

`default_nettype wire

@@ sv/multi_mode_byte_cipher.sv @@
// out_valid rises once an accepted item's result is loaded into the output register;
// in RC4 mode the RC4 step (read S[i], read S[j], write both, keystream read) comes first.
// A new item is taken once the last result is loaded; a stalled result holds the next one.
// First item of each message adds the RC4 key schedule (table fill, then key swaps),
// in every mode, keyed from the rc4 registers at that item.
// Reset (rst, sync, active high): default keys, mode 0, indices cleared, schedule pending.
// ----------------------------------------------------------------------------
// multi_mode_byte_cipher
// Byte cipher with pass, Caesar, XOR, Vigenere and RC4 modes.
// ----------------------------------------------------------------------------
`default_nettype none

module multi_mode_byte_cipher
  import mmbc_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  // input item channel
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [7:0]  data_byte,
  input  wire logic        last_byte,
  // result item channel
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [7:0]       out_byte,
  output logic             out_last,
  // configuration write channel
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [2:0]  cfg_index,
  input  wire logic [63:0] cfg_data
);

  dp_cmd_t    cmd;
  dp_status_t status;

  // register writes are always taken; the host must write only while idle, not enforced
  assign cfg_ready = 1'b1;

  // Sequencer: accepts an item only in its idle state. Because the result
  // sits in the datapath's output register, the sequencer goes back to idle
  // as soon as the result is loaded, so the next item can be taken while the
  // previous one still waits downstream.
  mmbc_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .status   (status),
    .cmd      (cmd)
  );

  // Datapath: configuration, the 256 x 8 permutation RAM, RC4 indices,
  // key position counters (mod 4 and mod 5) and the output register.
  mmbc_datapath u_dp (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .status    (status),
    .cfg_we    (cfg_valid && cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .data_byte (data_byte),
    .last_byte (last_byte),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_byte  (out_byte),
    .out_last  (out_last)
  );

endmodule

`default_nettype wire

@@ sv/mmbc_ram.sv @@
// ----------------------------------------------------------------------------
// mmbc_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module mmbc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

@@ sv/mmbc_ctrl.sv @@
// ----------------------------------------------------------------------------
// mmbc_ctrl
// Sequencer: input accept, key schedule, RC4 step and result hand-off.
// ----------------------------------------------------------------------------
`default_nettype none

module mmbc_ctrl
  import mmbc_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       in_valid,
  output logic            in_stall,
  input  wire dp_status_t status,
  output dp_cmd_t         cmd
);

  ctrl_state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd.op     = OP_NONE;
    in_stall   = 1'b1;
    unique case (state)
      ST_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          cmd.op = OP_LOAD;
          if (status.sched_pending) begin
            state_next = ST_FILL;
          end else if (status.rc4_mode) begin
            state_next = ST_PR_RD_I;
          end else begin
            state_next = ST_DONE;
          end
        end
      end
      ST_FILL: begin
        cmd.op = OP_FILL;
        if (status.cnt_max) begin
          state_next = ST_KS_RD_N;
        end
      end
      ST_KS_RD_N: begin
        cmd.op     = OP_KS_RD_N;
        state_next = ST_KS_RD_J;
      end
      ST_KS_RD_J: begin
        cmd.op     = OP_KS_RD_J;
        state_next = ST_KS_WR_N;
      end
      ST_KS_WR_N: begin
        cmd.op     = OP_KS_WR_N;
        state_next = ST_KS_WR_J;
      end
      ST_KS_WR_J: begin
        cmd.op = OP_KS_WR_J;
        if (!status.cnt_max) begin
          state_next = ST_KS_RD_N;
        end else if (status.rc4_mode) begin
          state_next = ST_PR_RD_I;
        end else begin
          state_next = ST_DONE;
        end
      end
      ST_PR_RD_I: begin
        cmd.op     = OP_PR_RD_I;
        state_next = ST_PR_RD_J;
      end
      ST_PR_RD_J: begin
        cmd.op     = OP_PR_RD_J;
        state_next = ST_PR_WR_I;
      end
      ST_PR_WR_I: begin
        cmd.op     = OP_PR_WR_I;
        state_next = ST_PR_WR_J;
      end
      ST_PR_WR_J: begin
        cmd.op     = OP_PR_WR_J;
        state_next = ST_PR_KS;
      end
      ST_PR_KS: begin
        cmd.op     = OP_PR_KS;
        state_next = ST_DONE;
      end
      ST_DONE: begin
        cmd.op = OP_FINISH;
        if (status.out_free) begin
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

endmodule

`default_nettype wire

@@ sv/mmbc_datapath.sv @@
// ----------------------------------------------------------------------------
// mmbc_datapath
// Config registers, permutation RAM, RC4 indices, byte transforms, output reg.
// ----------------------------------------------------------------------------
`default_nettype none

module mmbc_datapath
  import mmbc_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire dp_cmd_t     cmd,
  output dp_status_t       status,
  input  wire logic        cfg_we,
  input  wire logic [2:0]  cfg_index,
  input  wire logic [63:0] cfg_data,
  input  wire logic [7:0]  data_byte,
  input  wire logic        last_byte,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [7:0]       out_byte,
  output logic             out_last
);

  `include "multi_mode_byte_cipher_assert.svh"

  // configuration
  logic [2:0]   mode;
  logic [31:0]  xor_key;
  logic [39:0]  vigenere_key;
  logic [63:0]  rc4_key_low;
  logic [63:0]  rc4_key_high;

  // control state
  logic         sched_pending;
  logic [7:0]   rc4_i;
  logic [7:0]   rc4_j;
  logic [1:0]   pos4;
  logic [2:0]   pos5;
  logic [7:0]   cnt;

  // payload
  logic [7:0]   data_r;
  logic         last_r;
  logic [7:0]   si;
  logic [7:0]   sj;
  logic [7:0]   ks_addr;
  logic [7:0]   keystream;

  logic               ram_we;
  logic [PERM_AW-1:0] ram_waddr;
  logic [7:0]         ram_wdata;
  logic [PERM_AW-1:0] ram_raddr;
  logic [7:0]         ram_rdata;

  logic [127:0] rc4_key;
  logic [7:0]   key_byte;
  logic [7:0]   ks_j_next;
  logic [7:0]   pr_j_next;
  logic [7:0]   pr_i_next;
  logic [7:0]   xor_byte;
  logic [7:0]   vig_byte;
  logic [7:0]   result;
  logic         out_free;
  logic         finish;

  function automatic logic [7:0] shift_printable(input logic [7:0] c, input logic [6:0] sh);
    logic [8:0] s;
    begin
      s = {1'b0, c - PRINT_LO} + {2'b00, sh};
      if (s >= PRINT_SPAN) begin
        s = s - PRINT_SPAN;
      end
      if (c < PRINT_LO || c > PRINT_HI) begin
        shift_printable = c;
      end else begin
        shift_printable = s[7:0] + PRINT_LO;
      end
    end
  endfunction

  // (k - 32) mod 95, taken non-negative: (k + 63) mod 95 with k + 63 < 4 * 95
  function automatic logic [6:0] vig_shift(input logic [7:0] k);
    logic [8:0] x;
    begin
      x = {1'b0, k} + 9'd63;
      if (x >= 9'd285) begin
        x = x - 9'd285;
      end else if (x >= 9'd190) begin
        x = x - 9'd190;
      end else if (x >= PRINT_SPAN) begin
        x = x - PRINT_SPAN;
      end
      vig_shift = x[6:0];
    end
  endfunction

  mmbc_ram #(
    .WIDTH (8),
    .DEPTH (PERM_DEPTH)
  ) u_perm_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign rc4_key   = {rc4_key_high, rc4_key_low};
  assign key_byte  = rc4_key[{cnt[3:0], 3'b000} +: 8];
  assign ks_j_next = rc4_j + ram_rdata + key_byte;
  assign pr_j_next = rc4_j + ram_rdata;
  assign pr_i_next = rc4_i + 8'd1;

  assign xor_byte = xor_key[{pos4, 3'b000} +: 8];
  assign vig_byte = vigenere_key[{pos5, 3'b000} +: 8];

  assign out_free = !out_valid || !out_stall;
  assign finish   = (cmd.op == OP_FINISH) && out_free;

  assign status.sched_pending = sched_pending;
  assign status.rc4_mode      = (mode == MODE_RC4);
  assign status.cnt_max       = (cnt == 8'hFF);
  assign status.out_free      = out_free;

  // RAM port use per step
  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = cnt;
    ram_wdata = cnt;
    ram_raddr = cnt;
    unique case (cmd.op)
      OP_FILL: begin
        ram_we = 1'b1;
      end
      OP_KS_RD_J: begin
        ram_raddr = ks_j_next;
      end
      OP_KS_WR_N: begin
        ram_we    = 1'b1;
        ram_wdata = ram_rdata;
      end
      OP_KS_WR_J: begin
        ram_we    = 1'b1;
        ram_waddr = rc4_j;
        ram_wdata = si;
      end
      OP_PR_RD_I: begin
        ram_raddr = pr_i_next;
      end
      OP_PR_RD_J: begin
        ram_raddr = pr_j_next;
      end
      OP_PR_WR_I: begin
        ram_we    = 1'b1;
        ram_waddr = rc4_i;
        ram_wdata = ram_rdata;
      end
      OP_PR_WR_J: begin
        ram_we    = 1'b1;
        ram_waddr = rc4_j;
        ram_wdata = si;
        ram_raddr = si + sj;
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    case (mode)
      MODE_CAESAR: result = shift_printable(data_r, CAESAR_SHIFT);
      MODE_XOR:    result = data_r ^ xor_byte;
      MODE_VIG:    result = shift_printable(data_r, vig_shift(vig_byte));
      MODE_RC4:    result = data_r ^ keystream;
      default:     result = data_r;
    endcase
  end

  // control and configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      mode          <= MODE_PASS;
      xor_key       <= XOR_KEY_RST;
      vigenere_key  <= VIG_KEY_RST;
      rc4_key_low   <= RC4_LOW_RST;
      rc4_key_high  <= RC4_HIGH_RST;
      sched_pending <= 1'b1;
      rc4_i         <= '0;
      rc4_j         <= '0;
      pos4          <= '0;
      pos5          <= '0;
      cnt           <= '0;
      out_valid     <= 1'b0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          REG_MODE:     mode         <= cfg_data[2:0];
          REG_XOR_KEY:  xor_key      <= cfg_data[31:0];
          REG_VIG_KEY:  vigenere_key <= cfg_data[39:0];
          REG_RC4_LOW:  rc4_key_low  <= cfg_data;
          REG_RC4_HIGH: rc4_key_high <= cfg_data;
          default: begin
          end
        endcase
      end

      // a new result may replace one taken at the same edge
      if (finish) begin
        out_valid <= 1'b1;
      end else if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end

      case (cmd.op)
        OP_FILL: begin
          cnt   <= cnt + 8'd1;
          rc4_j <= '0;
        end
        OP_KS_RD_J: begin
          rc4_j <= ks_j_next;
        end
        OP_KS_WR_J: begin
          cnt <= cnt + 8'd1;
          if (cnt == 8'hFF) begin
            rc4_i         <= '0;
            rc4_j         <= '0;
            sched_pending <= 1'b0;
          end
        end
        OP_PR_RD_I: begin
          rc4_i <= pr_i_next;
        end
        OP_PR_RD_J: begin
          rc4_j <= pr_j_next;
        end
        OP_FINISH: begin
          if (out_free) begin
            if (last_r) begin
              pos4          <= '0;
              pos5          <= '0;
              rc4_i         <= '0;
              rc4_j         <= '0;
              sched_pending <= 1'b1;
            end else begin
              pos4 <= pos4 + 2'd1;
              pos5 <= (pos5 == 3'd4) ? 3'd0 : pos5 + 3'd1;
            end
          end
        end
        default: begin
        end
      endcase
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    case (cmd.op)
      OP_LOAD: begin
        data_r <= data_byte;
        last_r <= last_byte;
      end
      OP_KS_RD_J, OP_PR_RD_J: begin
        si <= ram_rdata;
      end
      OP_PR_WR_I: begin
        sj <= ram_rdata;
      end
      OP_PR_WR_J: begin
        ks_addr <= si + sj;
      end
      OP_PR_KS: begin
        // the keystream read overlapped the write of S[j]
        keystream <= (ks_addr == rc4_j) ? si : ram_rdata;
      end
      default: begin
      end
    endcase
    if (finish) begin
      out_byte <= result;
      out_last <= last_r;
    end
  end

  `MMBC_ASSERT_NOW(a_rc4_keyed, (cmd.op == OP_PR_RD_I), !sched_pending, "rc4 step on unkeyed table")
  `MMBC_ASSERT_NEXT(a_last_restart, (finish && last_r),
    (sched_pending && rc4_i == 8'd0 && rc4_j == 8'd0 && pos4 == 2'd0 && pos5 == 3'd0),
    "message end did not restart state")
  `MMBC_ASSERT_NOW(a_pos5_range, 1'b1, (pos5 <= 3'd4), "vigenere position out of range")
  `MMBC_ASSERT_NEXT(a_finish_loads, finish, out_valid, "finished item not presented")

endmodule

`default_nettype wire

@@ dv/mmbc_checker.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Multi-mode byte cipher checker
// Watches the three channels, keeps its own cipher state and compares every
// result item with the expected byte and last flag.
// ----------------------------------------------------------------------------

module mmbc_checker
  import mmbc_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  input  logic        in_stall,
  input  logic [7:0]  data_byte,
  input  logic        last_byte,
  input  logic        out_valid,
  input  logic        out_stall,
  input  logic [7:0]  out_byte,
  input  logic        out_last,
  input  logic        cfg_valid,
  input  logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [63:0] cfg_data,
  output int          mismatches,
  output int          outstanding
);

  localparam int POS_WRAP  = 20;
  localparam int MAX_SHOWN = 50;

  typedef struct packed {
    logic [7:0] cipher;
    logic       last;
  } cipher_item_t;

  cipher_item_t expected_cipher_q[$];

  // shadow registers
  logic [2:0]  mode_r;
  logic [31:0] xor_key_r;
  logic [39:0] vig_key_r;
  logic [63:0] rc4_lo_r;
  logic [63:0] rc4_hi_r;

  // cipher state
  logic [7:0]  sbox [PERM_DEPTH];
  logic [7:0]  idx_i;
  logic [7:0]  idx_j;
  logic [4:0]  pos;
  logic        rekey_due;

  int err_count  = 0;
  int results_in = 0;

  initial begin
    mismatches  = 0;
    outstanding = 0;
  end

  task automatic report_mismatch(input string what);
    if (err_count < MAX_SHOWN)
      $display("[%0t] mismatch at result %0d: %s", $time, results_in, what);
    err_count++;
  endtask

  task automatic rekey_sbox();
    logic [7:0]   j;
    logic [7:0]   t;
    logic [127:0] key;
    int           n;
    key = {rc4_hi_r, rc4_lo_r};
    for (n = 0; n < PERM_DEPTH; n++)
      sbox[n] = n[7:0];
    j = 8'd0;
    for (n = 0; n < PERM_DEPTH; n++) begin
      j       = j + sbox[n] + key[8*(n % 16) +: 8];
      t       = sbox[n];
      sbox[n] = sbox[j];
      sbox[j] = t;
    end
    idx_i     = 8'd0;
    idx_j     = 8'd0;
    rekey_due = 1'b0;
  endtask

  task automatic rc4_keystream(output logic [7:0] ks);
    logic [7:0] t;
    logic [7:0] sum;
    idx_i       = idx_i + 8'd1;
    idx_j       = idx_j + sbox[idx_i];
    t           = sbox[idx_i];
    sbox[idx_i] = sbox[idx_j];
    sbox[idx_j] = t;
    sum         = sbox[idx_i] + sbox[idx_j];
    ks          = sbox[sum];
  endtask

  // rotate within 32..126, anything else untouched
  function automatic logic [7:0] rotate_printable(input logic [7:0] c, input int shift);
    int r;
    if (c < PRINT_LO || c > PRINT_HI)
      return c;
    r = (int'(c) - int'(PRINT_LO) + shift) % int'(PRINT_SPAN) + int'(PRINT_LO);
    return r[7:0];
  endfunction

  task automatic encipher_byte(input logic [7:0] c, input logic last);
    cipher_item_t e;
    int           p;
    int           k;
    logic [7:0]   ks;
    p = int'(pos) % POS_WRAP;
    if (rekey_due)
      rekey_sbox();
    e.cipher = c;
    e.last   = last;
    case (mode_r)
      MODE_CAESAR: e.cipher = rotate_printable(c, int'(CAESAR_SHIFT));
      MODE_XOR:    e.cipher = c ^ xor_key_r[8*(p % 4) +: 8];
      MODE_VIG: begin
        k        = int'(vig_key_r[8*(p % 5) +: 8]);
        e.cipher = rotate_printable(c,
                     (k + int'(PRINT_SPAN) - int'(PRINT_LO)) % int'(PRINT_SPAN));
      end
      MODE_RC4: begin
        rc4_keystream(ks);
        e.cipher = c ^ ks;
      end
      default: ;
    endcase
    if (last) begin
      pos       = 5'd0;
      idx_i     = 8'd0;
      idx_j     = 8'd0;
      rekey_due = 1'b1;
    end else begin
      pos = 5'((p + 1) % POS_WRAP);
    end
    expected_cipher_q.push_back(e);
  endtask

  task automatic write_shadow(input logic [2:0] idx, input logic [63:0] val);
    case (idx)
      REG_MODE:     mode_r    = val[2:0];
      REG_XOR_KEY:  xor_key_r = val[31:0];
      REG_VIG_KEY:  vig_key_r = val[39:0];
      REG_RC4_LOW:  rc4_lo_r  = val;
      REG_RC4_HIGH: rc4_hi_r  = val;
      default: ;
    endcase
  endtask

  always @(posedge clk) begin
    cipher_item_t want;
    if (rst) begin
      mode_r    = MODE_PASS;
      xor_key_r = XOR_KEY_RST;
      vig_key_r = VIG_KEY_RST;
      rc4_lo_r  = RC4_LOW_RST;
      rc4_hi_r  = RC4_HIGH_RST;
      idx_i     = 8'd0;
      idx_j     = 8'd0;
      pos       = 5'd0;
      rekey_due = 1'b1;
      expected_cipher_q.delete();
    end else begin
      // results first: nothing accepted at this edge can already be out
      if (out_valid && !out_stall) begin
        if (expected_cipher_q.size() == 0) begin
          report_mismatch($sformatf("unexpected item byte %02h last %0b", out_byte, out_last));
        end else begin
          want = expected_cipher_q.pop_front();
          if (out_byte !== want.cipher)
            report_mismatch($sformatf("out_byte %02h, want %02h", out_byte, want.cipher));
          if (out_last !== want.last)
            report_mismatch($sformatf("out_last %0b, want %0b", out_last, want.last));
        end
        results_in++;
      end
      if (in_valid && !in_stall)
        encipher_byte(data_byte, last_byte);
      if (cfg_valid && cfg_ready)
        write_shadow(cfg_index, cfg_data);
    end
    outstanding <= expected_cipher_q.size();
    mismatches  <= err_count;
  end

endmodule

@@ dv/tb_multi_mode_byte_cipher.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Multi-mode byte cipher testbench
// Directed bytes per mode, then random phases of messages with register
// changes between them, bursty input, a patterned result stall and long
// hold-offs that back the block up. Checking lives in mmbc_checker.
// ----------------------------------------------------------------------------

module tb_multi_mode_byte_cipher
  import mmbc_pkg::*;
;

  localparam int       RANDOM_ITEMS = 1875;
  localparam int       HOLD_CYCLES  = 3000;   // longer than one key schedule
  localparam int       SETTLE       = 12;
  localparam int       TAIL_CYCLES  = 32;
  localparam longint   TIMEOUT_NS   = 120_000_000;

  // register indexes and modes that the block decodes to nothing
  localparam logic [2:0] REG_UNUSED_LO  = 3'd5;
  localparam logic [2:0] REG_UNUSED_HI  = 3'd7;
  localparam logic [2:0] MODE_SPARE_LO  = 3'd5;
  localparam logic [2:0] MODE_SPARE_HI  = 3'd7;

  logic        clk;
  logic        rst;
  logic        in_valid;
  logic        in_stall;
  logic [7:0]  data_byte;
  logic        last_byte;
  logic        out_valid;
  logic        out_stall;
  logic [7:0]  out_byte;
  logic        out_last;
  logic        cfg_valid;
  logic        cfg_ready;
  logic [2:0]  cfg_index;
  logic [63:0] cfg_data;

  int mismatches;
  int outstanding;

  int holds_asked = 0;   // bumped by the stimulus, served by the result sink
  int burst_left  = 0;
  int msg_left    = 0;   // bytes still due in the current message

  always begin
    clk = 1'b0;
    #4;
    clk = 1'b1;
    #4;
  end

  multi_mode_byte_cipher dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .data_byte (data_byte),
    .last_byte (last_byte),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_byte  (out_byte),
    .out_last  (out_last),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  mmbc_checker u_checker (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .data_byte   (data_byte),
    .last_byte   (last_byte),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .out_byte    (out_byte),
    .out_last    (out_last),
    .cfg_valid   (cfg_valid),
    .cfg_ready   (cfg_ready),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .mismatches  (mismatches),
    .outstanding (outstanding)
  );

  // Hard stop. Worst case for this stimulus is every item opening a message
  // (each paying the full key schedule) plus the longest gap and stall;
  // that is roughly 20 ms, so this is several times over.
  initial begin
    #(TIMEOUT_NS);
    $display("Regression FAIL");
    $finish;
  end

  // --------------------------------------------------------------------------
  // Result sink: runs of no stall, light stall, heavy stall and solid stall.
  // When the stimulus asks, it holds off for HOLD_CYCLES so the block backs
  // up and has to stall its input.
  // --------------------------------------------------------------------------
  initial begin : result_sink
    int run_left;
    int style;
    int holds_done;
    run_left   = 0;
    style      = 0;
    holds_done = 0;
    out_stall <= 1'b0;
    forever begin
      @(posedge clk);
      if (holds_done != holds_asked) begin
        holds_done++;
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES - 1) @(posedge clk);
      end else begin
        if (run_left == 0) begin
          run_left = $urandom_range(1, 40);
          style    = $urandom_range(0, 3);
        end
        run_left--;
        case (style)
          0:       out_stall <= 1'b0;
          1:       out_stall <= ($urandom_range(0, 3) == 0);
          2:       out_stall <= ($urandom_range(0, 9) < 7);
          default: out_stall <= 1'b1;
        endcase
      end
    end
  end

  // --------------------------------------------------------------------------
  // Sender helpers
  // --------------------------------------------------------------------------

  // bursts of random length; between bursts valid drops for a random gap,
  // sometimes not at all
  task automatic pace();
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 30);
      gap        = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
      if (gap != 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
  endtask

  // offer one item and hold it until taken
  task automatic send_byte(input logic [7:0] b, input logic last);
    pace();
    in_valid  <= 1'b1;
    data_byte <= b;
    last_byte <= last;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  // leaves cfg_valid high; the caller drops it after the last write
  task automatic write_reg(input logic [2:0] idx, input logic [63:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
  endtask

  // every result home, then a short settle before touching registers
  task automatic wait_idle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  // mostly printable text, some boundary bytes, the rest anything
  function automatic logic [7:0] pick_byte();
    logic [7:0] b;
    int         r;
    r = $urandom_range(0, 9);
    if (r < 5) begin
      b = 8'($urandom_range(PRINT_LO, PRINT_HI));
    end else if (r == 5) begin
      case ($urandom_range(0, 5))
        0:       b = 8'h00;
        1:       b = 8'hFF;
        2:       b = PRINT_LO - 8'd1;
        3:       b = PRINT_LO;
        4:       b = PRINT_HI;
        default: b = PRINT_HI + 8'd1;
      endcase
    end else begin
      b = 8'($urandom);
    end
    return b;
  endfunction

  // full 64 bits on purpose: upper bits beyond a register's width must drop
  function automatic logic [63:0] pick_key();
    logic [63:0] v;
    v = {$urandom, $urandom};
    case ($urandom_range(0, 5))
      0:       v = '0;
      1:       v = '1;
      default: ;
    endcase
    return v;
  endfunction

  // RC4 most often, since that is where the state lives
  function automatic logic [2:0] pick_mode();
    logic [2:0] m;
    case ($urandom_range(0, 9))
      0, 1, 2, 3: m = MODE_RC4;
      4:          m = MODE_PASS;
      5:          m = MODE_CAESAR;
      6:          m = MODE_XOR;
      7, 8:       m = MODE_VIG;
      default:    m = 3'($urandom_range(MODE_SPARE_LO, MODE_SPARE_HI));
    endcase
    return m;
  endfunction

  // --------------------------------------------------------------------------
  // Stimulus
  // --------------------------------------------------------------------------
  initial begin : stimulus
    int          phase;
    int          phase_len;
    int          sent;
    int          n;
    logic [63:0] v;

    rst       <= 1'b1;
    in_valid  <= 1'b0;
    data_byte <= 8'h00;
    last_byte <= 1'b0;
    cfg_valid <= 1'b0;
    cfg_index <= REG_MODE;
    cfg_data  <= '0;
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // ---- directed part ----

    // reset settings: pass mode, and the first byte still runs the schedule
    send_byte(8'h00, 1'b0);
    send_byte(8'hFF, 1'b0);
    send_byte(8'h41, 1'b1);
    wait_idle();

    // Caesar: either side of the printable range, the wrap at the top end,
    // and a high byte that must pass untouched
    write_reg(REG_MODE, 64'(MODE_CAESAR));
    cfg_valid <= 1'b0;
    send_byte(PRINT_LO - 8'd1, 1'b0);
    send_byte(PRINT_LO, 1'b0);
    send_byte(8'd124, 1'b0);
    send_byte(PRINT_HI, 1'b0);
    send_byte(PRINT_HI + 8'd1, 1'b0);
    send_byte(8'hFF, 1'b1);
    wait_idle();

    // XOR with the reset key, five bytes so the key index wraps once
    write_reg(REG_MODE, 64'(MODE_XOR));
    cfg_valid <= 1'b0;
    send_byte(8'h00, 1'b0);
    send_byte(8'hFF, 1'b0);
    send_byte(8'h5A, 1'b0);
    send_byte(8'hA5, 1'b0);
    send_byte(8'h3C, 1'b1);
    wait_idle();

    // Vigenere with non-printable key bytes (0x00 and 0xFF) at the front;
    // upper data bits must be dropped by the 40-bit register
    write_reg(REG_VIG_KEY, {24'hFFFFFF, 8'h7E, 8'h20, 8'h41, 8'hFF, 8'h00});
    write_reg(REG_MODE, 64'(MODE_VIG));
    cfg_valid <= 1'b0;
    send_byte(PRINT_LO, 1'b0);
    send_byte(PRINT_HI, 1'b0);
    send_byte(8'h41, 1'b0);
    send_byte(8'h80, 1'b0);
    send_byte(8'h7D, 1'b1);
    wait_idle();

    // RC4 with the reset key
    write_reg(REG_MODE, 64'(MODE_RC4));
    cfg_valid <= 1'b0;
    send_byte(8'h00, 1'b0);
    send_byte(8'hFF, 1'b0);
    send_byte(8'h00, 1'b0);
    send_byte(8'h55, 1'b1);
    wait_idle();

    // unused modes pass through; writes to unused indexes change nothing
    write_reg(REG_UNUSED_HI, '1);
    write_reg(REG_UNUSED_LO, '0);
    write_reg(REG_MODE, 64'(MODE_SPARE_HI));
    cfg_valid <= 1'b0;
    send_byte(8'h80, 1'b0);
    wait_idle();
    write_reg(REG_MODE, 64'(MODE_SPARE_LO));
    cfg_valid <= 1'b0;
    send_byte(8'h7F, 1'b1);
    wait_idle();

    // ---- random phases ----
    // Phases end wherever they happen to, often mid-message, so mode
    // changes inside a message and RC4 key writes that only apply to the
    // next message both come up.
    phase = 0;
    sent  = 0;
    while (sent < RANDOM_ITEMS) begin
      wait_idle();
      v      = {$urandom, $urandom};
      v[2:0] = pick_mode();
      write_reg(REG_MODE, v);
      if (phase == 1) begin
        write_reg(REG_XOR_KEY, '0);
        write_reg(REG_VIG_KEY, '0);
        write_reg(REG_RC4_LOW, '0);
        write_reg(REG_RC4_HIGH, '0);
      end else if (phase == 2) begin
        write_reg(REG_XOR_KEY, '1);
        write_reg(REG_VIG_KEY, '1);
        write_reg(REG_RC4_LOW, '1);
        write_reg(REG_RC4_HIGH, '1);
      end else begin
        if ($urandom_range(0, 2) == 0) write_reg(REG_XOR_KEY, pick_key());
        if ($urandom_range(0, 2) == 0) write_reg(REG_VIG_KEY, pick_key());
        if ($urandom_range(0, 2) == 0) write_reg(REG_RC4_LOW, pick_key());
        if ($urandom_range(0, 2) == 0) write_reg(REG_RC4_HIGH, pick_key());
      end
      if ($urandom_range(0, 7) == 0)
        write_reg(3'($urandom_range(REG_UNUSED_LO, REG_UNUSED_HI)), pick_key());
      cfg_valid <= 1'b0;

      // long receiver hold-offs while the sender keeps offering
      if (phase == 3 || phase == 20)
        holds_asked++;

      phase_len = $urandom_range(10, 90);
      for (n = 0; n < phase_len && sent < RANDOM_ITEMS; n++) begin
        if (msg_left == 0)
          msg_left = ($urandom_range(0, 19) < 17) ? $urandom_range(1, 24)
                                                   : $urandom_range(25, 64);
        msg_left--;
        send_byte(pick_byte(), msg_left == 0);
        sent++;
      end
      phase++;
    end

    // ---- drain and verdict ----
    in_valid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
    if (mismatches == 0 && outstanding == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
